@@ hdl/lstg_pkg.sv @@
`default_nettype none
package lstg_pkg;

    localparam int PIX_W = 6;
    localparam int LEN_W = 7;
    localparam int COLOR_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_W = 14;
    localparam int DEN_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMET_COLOR  = 3'd0,
        CFG_TRAIL_LENGTH = 3'd1,
        CFG_COMET_COUNT  = 3'd2,
        CFG_MOTION_MODE  = 3'd3,
        CFG_STRIP_LENGTH = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MOVE_FORWARD  = 2'd0,
        MOVE_BACKWARD = 2'd1,
        MOVE_BOUNCE   = 2'd2,
        MOVE_SPARE    = 2'd3
    } move_mode_t;

    typedef struct packed {
        logic load;
        logic sp_start;
        logic sp_take;
        logic clr;
        logic paint;
        logic rd;
        logic br_start;
        logic out_load;
        logic pix_adv;
        logic move;
    } lstg_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic clr_last;
        logic paint_act;
        logic lit;
        logic out_taken;
        logic pix_last;
    } lstg_stat_t;

endpackage
`default_nettype wire

@@ hdl/lstg_req_if.sv @@
`default_nettype none
interface lstg_req_if;
    logic                 valid;
    logic                 ready;
    logic                 override_valid;
    logic [5:0]           override_index;

    modport source (output valid, output override_valid, output override_index, input ready);
    modport sink   (input valid, input override_valid, input override_index, output ready);
endinterface
`default_nettype wire

@@ hdl/lstg_pix_if.sv @@
`default_nettype none
interface lstg_pix_if;
    logic                 valid;
    logic                 ready;
    logic [5:0]           pixel_index;
    logic [23:0]          pixel_color;
    logic                 frame_last;

    modport source (output valid, output pixel_index, output pixel_color, output frame_last,
                    input ready);
    modport sink   (input valid, input pixel_index, input pixel_color, input frame_last,
                    output ready);
endinterface
`default_nettype wire

@@ hdl/lstg_divider.sv @@
`default_nettype none
module lstg_divider
    import lstg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic [NUM_W-1:0]      quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            den_next = den;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;
endmodule
`default_nettype wire

@@ hdl/lstg_datapath.sv @@
`default_nettype none
module lstg_datapath
    import lstg_pkg::*;
#(
    parameter int MAX_PIXELS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    input  wire logic                 ovr_valid,
    input  wire logic [PIX_W-1:0]     ovr_index,
    input  wire lstg_cmd_t            cmd,
    output lstg_stat_t                stat,
    lstg_pix_if.source                pix
);
    localparam int AW = $clog2(MAX_PIXELS);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PIXELS);

    logic [COLOR_W-1:0] color_reg;
    logic [7:0]         trail_reg;
    logic [LEN_W-1:0]   count_reg;
    move_mode_t         mode_reg;
    logic [LEN_W-1:0]   slen_reg;

    logic [LEN_W-1:0]   len_reg, len_next;
    logic [PIX_W-1:0]   pos_reg, pos_next;
    logic               bounce_reg, bounce_next;
    logic [LEN_W-1:0]   spacing_reg;
    logic [LEN_W-1:0]   inst_reg;
    logic [PIX_W-1:0]   i_reg;
    logic [PIX_W-1:0]   base_reg;
    logic [PIX_W-1:0]   idx_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [PIX_W:0]     rd_reg;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_index_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    logic [PIX_W:0]     mem [MAX_PIXELS];

    logic [PIX_W-1:0]   last_pix;
    logic [PIX_W-1:0]   pos_src;
    logic [LEN_W-1:0]   limit;
    logic               i_last;
    logic [LEN_W-1:0]   base_sum;
    logic [PIX_W-1:0]   base_wrap;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_busy;
    logic [NUM_W-1:0]   div_quo;
    logic [7:0]         bright;
    logic [COLOR_W-1:0] faded;

    function automatic logic [7:0] scale_ch(input logic [7:0] c, input logic [7:0] f);
        logic [15:0] x;
        logic [16:0] y;
        x = c * f;
        y = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return y[15:8];
    endfunction

    lstg_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    always_comb
    begin
        if (slen_reg == '0)
            len_next = LEN_W'(1);
        else if (slen_reg > LEN_MAX)
            len_next = LEN_MAX;
        else
            len_next = slen_reg;
        pos_src = ovr_valid ? ovr_index : pos_reg;
        if ({1'b0, pos_src} >= len_next)
            pos_next = PIX_W'(len_next - 1'b1);
        else
            pos_next = pos_src;
        bounce_next = ovr_valid ? 1'b0 : bounce_reg;
    end

    assign last_pix  = PIX_W'(len_reg - 1'b1);
    assign limit     = (trail_reg >= {1'b0, len_reg}) ? len_reg : trail_reg[LEN_W-1:0];
    assign i_last    = ({1'b0, i_reg} + 1'b1) == limit;
    assign base_sum  = {1'b0, base_reg} + spacing_reg;
    assign base_wrap = (base_sum >= len_reg) ? PIX_W'(base_sum - len_reg) : PIX_W'(base_sum);

    assign div_start = cmd.sp_start | cmd.br_start;
    assign div_num   = cmd.sp_start ? NUM_W'(len_reg)
                                    : ({rd_reg[PIX_W-1:0], 8'b0} - NUM_W'(rd_reg[PIX_W-1:0]));
    assign div_den   = cmd.sp_start ? DEN_W'(count_reg) : trail_reg;

    assign bright = 8'hFF - div_quo[7:0];
    assign faded  = {scale_ch(color_reg[23:16], bright),
                     scale_ch(color_reg[15:8], bright),
                     scale_ch(color_reg[7:0], bright)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= 24'hFFFFFF;
            trail_reg     <= 8'd4;
            count_reg     <= LEN_W'(1);
            mode_reg      <= MOVE_FORWARD;
            slen_reg      <= LEN_W'(64);
            pos_reg       <= '0;
            bounce_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_COMET_COLOR:  color_reg <= cfg_data;
                    CFG_TRAIL_LENGTH: trail_reg <= cfg_data[7:0];
                    CFG_COMET_COUNT:  count_reg <= cfg_data[LEN_W-1:0];
                    CFG_MOTION_MODE:  mode_reg  <= move_mode_t'(cfg_data[1:0]);
                    CFG_STRIP_LENGTH: slen_reg  <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                pos_reg    <= pos_next;
                bounce_reg <= bounce_next;
            end
            else if (cmd.move)
            begin
                unique case (mode_reg)
                    MOVE_BOUNCE:
                    begin
                        if (pos_reg >= last_pix)
                        begin
                            bounce_reg <= 1'b1;
                            if (pos_reg != '0)
                                pos_reg <= pos_reg - 1'b1;
                        end
                        else if (pos_reg == '0)
                        begin
                            bounce_reg <= 1'b0;
                            pos_reg    <= pos_reg + 1'b1;
                        end
                        else if (bounce_reg)
                            pos_reg <= pos_reg - 1'b1;
                        else
                            pos_reg <= pos_reg + 1'b1;
                    end
                    MOVE_BACKWARD:
                        pos_reg <= (pos_reg == '0) ? last_pix : pos_reg - 1'b1;
                    default:
                        pos_reg <= (pos_reg >= last_pix) ? '0 : pos_reg + 1'b1;
                endcase
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (pix.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            len_reg <= len_next;
        if (cmd.sp_take)
        begin
            spacing_reg <= (count_reg > LEN_W'(1)) ? div_quo[LEN_W-1:0] : len_reg;
            inst_reg    <= '0;
            i_reg       <= '0;
            base_reg    <= pos_reg;
            idx_reg     <= pos_reg;
            pix_reg     <= '0;
        end
        else if (cmd.clr)
        begin
            pix_reg <= (pix_reg == last_pix) ? '0 : pix_reg + 1'b1;
        end
        else if (cmd.paint)
        begin
            if (i_last)
            begin
                i_reg    <= '0;
                inst_reg <= inst_reg + 1'b1;
                base_reg <= base_wrap;
                idx_reg  <= base_wrap;
            end
            else
            begin
                i_reg   <= i_reg + 1'b1;
                idx_reg <= (idx_reg == '0) ? last_pix : idx_reg - 1'b1;
            end
        end
        else if (cmd.pix_adv)
        begin
            pix_reg <= pix_reg + 1'b1;
        end
        if (cmd.clr)
            mem[pix_reg[AW-1:0]] <= '0;
        else if (cmd.paint)
            mem[idx_reg[AW-1:0]] <= {1'b1, i_reg};
        if (cmd.rd)
            rd_reg <= mem[pix_reg[AW-1:0]];
        if (cmd.out_load)
        begin
            out_index_reg <= pix_reg;
            out_color_reg <= rd_reg[PIX_W] ? faded : '0;
            out_last_reg  <= (pix_reg == last_pix);
        end
    end

    assign stat.div_busy  = div_busy;
    assign stat.clr_last  = (pix_reg == last_pix);
    assign stat.paint_act = (inst_reg < count_reg) && (limit != '0);
    assign stat.lit       = rd_reg[PIX_W];
    assign stat.out_taken = out_valid_reg & pix.ready;
    assign stat.pix_last  = out_last_reg;

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_index = out_index_reg;
    assign pix.pixel_color = out_color_reg;
    assign pix.frame_last  = out_last_reg;
endmodule
`default_nettype wire

@@ hdl/lstg_ctrl.sv @@
`default_nettype none
module lstg_ctrl
    import lstg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire lstg_stat_t stat,
    output lstg_cmd_t       cmd
);
    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_SPSTART = 11'b000_0000_0010,
        S_SPWAIT  = 11'b000_0000_0100,
        S_CLEAR   = 11'b000_0000_1000,
        S_PAINT   = 11'b000_0001_0000,
        S_READ    = 11'b000_0010_0000,
        S_BRSTART = 11'b000_0100_0000,
        S_BRWAIT  = 11'b000_1000_0000,
        S_SCALE   = 11'b001_0000_0000,
        S_OUT     = 11'b010_0000_0000,
        S_MOVE    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SPSTART;
                end
            end
            S_SPSTART:
            begin
                cmd.sp_start = 1'b1;
                state_next   = S_SPWAIT;
            end
            S_SPWAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.sp_take = 1'b1;
                    state_next  = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                    state_next = S_PAINT;
            end
            S_PAINT:
            begin
                if (stat.paint_act)
                    cmd.paint = 1'b1;
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_BRSTART;
            end
            S_BRSTART:
            begin
                if (stat.lit)
                begin
                    cmd.br_start = 1'b1;
                    state_next   = S_BRWAIT;
                end
                else
                    state_next = S_SCALE;
            end
            S_BRWAIT:
            begin
                if (!stat.div_busy)
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_taken)
                begin
                    if (stat.pix_last)
                        state_next = S_MOVE;
                    else
                    begin
                        cmd.pix_adv = 1'b1;
                        state_next  = S_READ;
                    end
                end
            end
            S_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

@@ hdl/led_sweep_trail_generator_top.sv @@
`default_nettype none
// channel   role    payload                                 transaction
// req       sink    override_valid, override_index          one frame request
// pix       source  pixel_index, pixel_color, frame_last    one pixel of the frame
// cfg       write   cfg_we, cfg_index, cfg_data             one register write
//
// A frame clears L buffer entries, paints C*min(T,L) trail pixels, then reads and
// sends L pixels (L strip length, C comets, T trail length): the frame buffer
// clear and paint use one memory write port, and each lit pixel waits on the shared
// divider for its brightness. One frame is in work at a time; req is ready only
// between frames. A stall on pix holds the pixel register and the controller.
// rst_n clears the registers to their reset values, the position and the direction.
module led_sweep_trail_generator_top
    import lstg_pkg::*;
#(
    parameter int MAX_PIXELS = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]   cfg_data,
    lstg_req_if.sink                  req,
    lstg_pix_if.source                pix
);
    lstg_cmd_t  cmd;
    lstg_stat_t stat;
    logic       req_ready;

    assign req.ready = req_ready;

    lstg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lstg_datapath #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ovr_valid (req.override_valid),
        .ovr_index (req.override_index),
        .cmd       (cmd),
        .stat      (stat),
        .pix       (pix)
    );
endmodule
`default_nettype wire

@@ bench/led_sweep_trail_generator_top_test.sv @@
`timescale 1ns / 1ps
module led_sweep_trail_generator_top_test
    import lstg_pkg::*;
();

    typedef struct packed {
        logic       override_valid;
        logic [5:0] override_index;
    } frame_req_t;

    typedef struct packed {
        logic [5:0]  pixel_index;
        logic [23:0] pixel_color;
        logic        frame_last;
    } pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0] cfg_data;

    lstg_req_if req ();
    lstg_pix_if pix ();

    led_sweep_trail_generator_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req.sink),
        .pix(pix.source)
    );

    frame_req_t pending_reqs[$];
    pixel_t expected_pixels[$];

    logic [23:0] shadow_color;
    logic [7:0] shadow_trail;
    logic [6:0] shadow_count;
    logic [1:0] shadow_mode;
    logic [6:0] shadow_strip;
    logic [5:0] head_pos;
    logic bouncing_back;

    int errors = 0;
    int cycles = 0;
    bit quiet_tail;
    int hold_off = 0;
    bit stall_arm = 1'b0;
    bit stall_done = 1'b0;
    int send_gap;
    int recv_gap;

    function automatic logic [23:0] fade(logic [23:0] c, int f);
        int r, g, b;
        r = c[23:16] * f / 255;
        g = c[15:8] * f / 255;
        b = c[7:0] * f / 255;
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

    function automatic void render_frame(frame_req_t rq);
        logic [23:0] frame [64];
        int len, pos, spacing, base, idx, f;
        pixel_t p;
        len = shadow_strip;
        if (len == 0) len = 1;
        if (len > 64) len = 64;
        pos = head_pos;
        if (pos >= len) pos = len - 1;
        if (rq.override_valid)
        begin
            pos = rq.override_index;
            if (pos >= len) pos = len - 1;
            bouncing_back = 1'b0;
        end
        for (int k = 0; k < 64; k++) frame[k] = '0;
        spacing = (shadow_count > 1) ? len / shadow_count : len;
        for (int c = 0; c < shadow_count; c++)
        begin
            base = (pos + c * spacing) % len;
            for (int i = 0; i < shadow_trail && i < len; i++)
            begin
                idx = (base + len - i) % len;
                f = 255 - (i * 255) / shadow_trail;
                frame[idx] = fade(shadow_color, f);
            end
        end
        for (int i = 0; i < len; i++)
        begin
            p.pixel_index = i[5:0];
            p.pixel_color = frame[i];
            p.frame_last = (i == len - 1);
            expected_pixels.push_back(p);
        end
        if (shadow_mode == MOVE_BOUNCE)
        begin
            if (pos >= len - 1) bouncing_back = 1'b1;
            else if (pos == 0) bouncing_back = 1'b0;
            if (bouncing_back)
            begin
                if (pos > 0) pos--;
            end
            else
                pos++;
        end
        else if (shadow_mode == MOVE_BACKWARD)
            pos = (pos + len - 1) % len;
        else
            pos = (pos + 1) % len;
        head_pos = pos[5:0];
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.override_valid <= 1'b0;
            req.override_index <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                render_frame({req.override_valid, req.override_index});
                void'(pending_reqs.pop_front());
            end
            if (req.valid && !req.ready)
                ;
            else if (send_gap > 0)
            begin
                req.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if ((pending_reqs.size() > 0)
                     && !(!quiet_tail && $urandom_range(0, 9) == 0))
            begin
                frame_req_t nx;
                nx = pending_reqs[0];
                req.valid <= 1'b1;
                req.override_valid <= nx.override_valid;
                req.override_index <= nx.override_index;
            end
            else
            begin
                req.valid <= 1'b0;
                if (!quiet_tail && pending_reqs.size() > 0) send_gap <= $urandom_range(1, 18);
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (pix.valid && pix.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected pixel index %0d", pix.pixel_index);
                    errors++;
                end
                else
                begin
                    pixel_t e;
                    e = expected_pixels.pop_front();
                    if (pix.pixel_index !== e.pixel_index)
                    begin
                        $error("pixel_index expected %0d actual %0d",
                               e.pixel_index, pix.pixel_index);
                        errors++;
                    end
                    if (pix.pixel_color !== e.pixel_color)
                    begin
                        $error("pixel_color expected %06h actual %06h",
                               e.pixel_color, pix.pixel_color);
                        errors++;
                    end
                    if (pix.frame_last !== e.frame_last)
                    begin
                        $error("frame_last expected %0d actual %0d",
                               e.frame_last, pix.frame_last);
                        errors++;
                    end
                end
            end
            if (hold_off > 0)
                pix.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                pix.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (!quiet_tail && $urandom_range(0, 19) == 0)
            begin
                pix.ready <= 1'b0;
                recv_gap <= $urandom_range(0, 17);
            end
            else
                pix.ready <= 1'b1;
        end
    end

    // long receiver stall
    always @(posedge clk)
    begin
        if (stall_arm && !stall_done)
        begin
            hold_off <= 600;
            stall_done <= 1'b1;
        end
        else if (hold_off > 0)
            hold_off <= hold_off - 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 30000000)
        begin
            $display("led_sweep_trail_generator_top: mismatch");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [COLOR_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_COMET_COLOR: shadow_color = val;
            CFG_TRAIL_LENGTH: shadow_trail = val[7:0];
            CFG_COMET_COUNT: shadow_count = val[6:0];
            CFG_MOTION_MODE: shadow_mode = val[1:0];
            CFG_STRIP_LENGTH: shadow_strip = val[6:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || expected_pixels.size() > 0 || req.valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_frames(int n, int ov_pct);
        frame_req_t r;
        for (int k = 0; k < n; k++)
        begin
            r.override_valid = ($urandom_range(0, 99) < ov_pct);
            r.override_index = 6'($urandom_range(0, 63));
            pending_reqs.push_back(r);
        end
    endtask

    task automatic random_config();
        int pick;
        write_reg(CFG_COMET_COLOR, 24'($urandom_range(0, 24'hFFFFFF)));
        pick = $urandom_range(0, 9);
        write_reg(CFG_TRAIL_LENGTH,
                  24'(pick == 0 ? 0 : pick == 1 ? 255 : $urandom_range(1, 12)));
        pick = $urandom_range(0, 9);
        write_reg(CFG_COMET_COUNT,
                  24'(pick == 0 ? 0 : pick == 1 ? 64 : $urandom_range(1, 6)));
        write_reg(CFG_MOTION_MODE, 24'($urandom_range(0, 3)));
        pick = $urandom_range(0, 9);
        write_reg(CFG_STRIP_LENGTH, 24'(pick == 0 ? 0 : pick == 1 ? 127 :
                  pick == 2 ? 64 : $urandom_range(1, 20)));
    endtask

    initial
    begin
        frame_req_t r;
        quiet_tail = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_COMET_COLOR;
        cfg_data = '0;
        shadow_color = 24'hFFFFFF;
        shadow_trail = 8'd4;
        shadow_count = 7'd1;
        shadow_mode = MOVE_FORWARD;
        shadow_strip = 7'd64;
        head_pos = '0;
        bouncing_back = 1'b0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, overrides at both ends
        r = '{1'b0, 6'd0}; pending_reqs.push_back(r);
        r = '{1'b1, 6'd63}; pending_reqs.push_back(r);
        r = '{1'b1, 6'd0}; pending_reqs.push_back(r);
        drain();

        write_reg(CFG_COMET_COLOR, 24'h80FF01);
        write_reg(CFG_TRAIL_LENGTH, 24'd255);
        write_reg(CFG_COMET_COUNT, 24'd64);
        write_reg(CFG_MOTION_MODE, 24'(MOVE_BACKWARD));
        write_reg(CFG_STRIP_LENGTH, 24'd127);
        r = '{1'b1, 6'd42}; pending_reqs.push_back(r);
        r = '{1'b0, 6'd21}; pending_reqs.push_back(r);
        drain();

        write_reg(CFG_TRAIL_LENGTH, 24'd0);
        write_reg(CFG_COMET_COUNT, 24'd0);
        write_reg(CFG_STRIP_LENGTH, 24'd0);
        write_reg(CFG_MOTION_MODE, 24'(MOVE_SPARE));
        queue_frames(2, 50);
        drain();

        // bounce, stale position after shortening, coinciding comets
        write_reg(CFG_COMET_COLOR, 24'hFFFFFF);
        write_reg(CFG_TRAIL_LENGTH, 24'd3);
        write_reg(CFG_COMET_COUNT, 24'd5);
        write_reg(CFG_MOTION_MODE, 24'(MOVE_BOUNCE));
        write_reg(CFG_STRIP_LENGTH, 24'd4);
        r = '{1'b1, 6'd2}; pending_reqs.push_back(r);
        queue_frames(6, 0);
        drain();
        write_reg(CFG_STRIP_LENGTH, 24'd1);
        queue_frames(3, 0);
        drain();
        write_reg(CFG_STRIP_LENGTH, 24'd40);
        r = '{1'b1, 6'd39}; pending_reqs.push_back(r);
        queue_frames(3, 0);
        drain();

        // receiver holds off while requests keep coming
        queue_frames(4, 30);
        stall_arm = 1'b1;
        drain();

        for (int ph = 0; ph < 30; ph++)
        begin
            random_config();
            if (ph >= 27) quiet_tail = 1'b1;
            queue_frames(15, 25);
            drain();
        end

        if (errors == 0)
            $display("led_sweep_trail_generator_top: match");
        else
            $display("led_sweep_trail_generator_top: mismatch");
        $finish;
    end
endmodule

@@ files.f @@
hdl/lstg_pkg.sv
hdl/lstg_req_if.sv
hdl/lstg_pix_if.sv
hdl/lstg_divider.sv
hdl/lstg_datapath.sv
hdl/lstg_ctrl.sv
hdl/led_sweep_trail_generator_top.sv
bench/led_sweep_trail_generator_top_test.sv
